// ===== design/ptu_pkg.sv =====
package ptu_pkg;

  localparam int NUM_PARTICLES = 64;
  localparam int IDX_W = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
  localparam int SLOT_W = 6;
  localparam int POS_W = 18;
  localparam int VEL_W = 13;
  localparam int LIFE_W = 17;
  localparam int DT_W = 16;
  localparam int GRAV_W = 12;
  localparam int SS_W = 8;
  localparam int COL_W = 8;
  localparam int CFG_W = 17;
  localparam int MUL_A_W = 22;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PARTICLES - 1);

  // Register indexes of the configuration port
  localparam logic [1:0] REG_GRAVITY = 2'd0;
  localparam logic [1:0] REG_SPEED_SCALE = 2'd1;
  localparam logic [1:0] REG_SPAWN_LIFE = 2'd2;

  // Codes on the input and output tuser lines
  localparam logic OP_SPAWN = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_SP_SCAN  = 12'b0000_0000_0010,
    S_SP_OUT   = 12'b0000_0000_0100,
    S_TK_GRAV  = 12'b0000_0000_1000,
    S_TK_DVY   = 12'b0000_0001_0000,
    S_TK_SCAN  = 12'b0000_0010_0000,
    S_TK_VY    = 12'b0000_0100_0000,
    S_TK_MX    = 12'b0000_1000_0000,
    S_TK_MY    = 12'b0001_0000_0000,
    S_TK_MY2   = 12'b0010_0000_0000,
    S_TK_WB    = 12'b0100_0000_0000,
    S_TK_FLUSH = 12'b1000_0000_0000
  } state_e;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic [COL_W-1:0]        green;
    logic [LIFE_W-1:0]       life;
  } entry_t;

  typedef struct packed {
    logic                    kind;
    logic                    ok;
    logic [SLOT_W-1:0]       slot;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic [COL_W-1:0]        green;
    logic [7:0]              alpha;
    logic                    last;
  } beat_t;

  // floor(life * 255 / 2^16), clamped at 255
  function automatic logic [7:0] alpha_of(input logic [LIFE_W-1:0] life);
    logic [LIFE_W+7:0] m;
    m = {life, 8'b0} - {8'b0, life};
    return (m[LIFE_W+7:16] > 9'd255) ? 8'd255 : m[23:16];
  endfunction

endpackage

// ===== design/particle_table_update.sv =====
// Particle table with Euler integration under constant gravity.
// Input beats arrive on s_axis: tuser selects spawn or tick, tdata carries the
// spawn fields and the tick time step. Results leave on m_axis: tuser gives
// the kind (spawn acknowledgement or live particle report), tlast marks the
// final result of an input beat. A tick with no survivors gives no result.
// Configuration (gravity, speed scale, spawn life) is written through
// cfg_we_i / cfg_idx_i / cfg_data_i; the user must write it only while the
// block is idle, as the block itself does not enforce this. One input beat is
// worked on at a time; s_axis_tready is high in idle. A spawn scans the alive
// flags one slot a cycle. A tick first works out the gravity step, then scans
// dead slots one a cycle and takes each live slot through its velocity, x-move,
// y-move and writeback states, since each live slot uses the single shared
// multiplier four times. Reports are held one behind so the last can be marked;
// a stalled receiver stalls the sequencer through the output register.
// Reset clears all particles to dead and loads the default configuration.
module particle_table_update
  import ptu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // spawn_x[10:0], spawn_y[21:11], spawn_vx[34:22], spawn_vy[47:35],
  // spawn_green[55:48], step_time[71:56]
  input  logic [71:0]       s_axis_tdata,
  // opcode
  input  logic              s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // spawned_ok[0], slot[6:1], pos_x[24:7], pos_y[42:25], green[50:43],
  // alpha[58:51], zero[63:59]
  output logic [63:0]       m_axis_tdata,
  // kind
  output logic              m_axis_tuser,
  output logic              m_axis_tlast,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  state_e state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [NUM_PARTICLES-1:0] alive_q, alive_d;
  logic [GRAV_W-1:0] grav_q;
  logic [SS_W-1:0] ss_q;
  logic [LIFE_W-1:0] slife_q;
  logic [71:0] in_q, in_d;
  logic [GRAV_W-1:0] dvy_q, dvy_d;
  logic signed [VEL_W-1:0] vy_q, vy_d;
  logic signed [POS_W-1:0] px_q, px_d;
  logic pend_v_q, pend_v_d;
  beat_t pend_q, pend_d;
  logic out_v_q, out_v_d;
  beat_t out_q, out_d;

  entry_t mem [NUM_PARTICLES];
  entry_t rd_q, wdata;
  logic we;

  logic mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  logic out_free, in_acc, is_last;
  logic signed [VEL_W+1:0] vy_sum;
  logic signed [POS_W+3:0] pos_sum;
  logic signed [POS_W-1:0] pos_sat;
  logic [LIFE_W-1:0] life_new;
  logic [DT_W-1:0] dt;

  ptu_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign dt = in_q[71:56];
  assign out_free = !out_v_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign is_last = (idx_q == LAST_IDX);

  // Position update shared by x and y: add floor(prod / 2^18) and saturate
  always_comb begin
    logic signed [POS_W-1:0] base;
    base = (state_q == S_TK_MY) ? rd_q.x : rd_q.y;
    pos_sum = $signed({{4{base[POS_W-1]}}, base}) +
              $signed({prod[MUL_P_W-1], prod[MUL_P_W-1:18]});
    if (pos_sum > (POS_W+4)'(131071)) begin
      pos_sat = 18'sh1FFFF;
    end else if (pos_sum < -(POS_W+4)'(131072)) begin
      pos_sat = 18'sh20000;
    end else begin
      pos_sat = pos_sum[POS_W-1:0];
    end
  end

  assign vy_sum = {{2{rd_q.vy[VEL_W-1]}}, rd_q.vy} + $signed({3'b0, dvy_q});
  assign life_new = (rd_q.life > LIFE_W'(dt)) ? rd_q.life - LIFE_W'(dt) : '0;

  // Sequencer
  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    alive_d = alive_q;
    in_d = in_q;
    dvy_d = dvy_q;
    vy_d = vy_q;
    px_d = px_q;
    pend_v_d = pend_v_q;
    pend_d = pend_q;
    out_v_d = out_v_q && !m_axis_tready;
    out_d = out_q;
    we = 1'b0;
    wdata = rd_q;
    mul_en = 1'b0;
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          in_d = s_axis_tdata;
          idx_d = '0;
          state_d = (s_axis_tuser == OP_SPAWN) ? S_SP_SCAN : S_TK_GRAV;
        end
      end
      S_SP_SCAN: begin
        // Build the acknowledgement aside; the output register may still hold a beat
        pend_d = '0;
        pend_d.kind = KIND_ACK;
        pend_d.last = 1'b1;
        if (!alive_q[idx_q]) begin
          wdata.x = {in_q[10:0], 6'b0};
          wdata.y = {in_q[21:11], 6'b0};
          wdata.vx = in_q[34:22];
          wdata.vy = in_q[47:35];
          wdata.green = in_q[55:48];
          wdata.life = slife_q;
          we = 1'b1;
          alive_d[idx_q] = (slife_q != '0);
          pend_d.ok = 1'b1;
          pend_d.slot = SLOT_W'(idx_q);
          pend_d.px = wdata.x;
          pend_d.py = wdata.y;
          pend_d.green = wdata.green;
          pend_d.alpha = alpha_of(slife_q);
          state_d = S_SP_OUT;
        end else if (is_last) begin
          state_d = S_SP_OUT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SP_OUT: begin
        if (out_free) begin
          out_d = pend_q;
          out_v_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_TK_GRAV: begin
        mul_en = 1'b1;
        mul_a = MUL_A_W'(grav_q);
        mul_b = MUL_B_W'(dt);
        state_d = S_TK_DVY;
      end
      S_TK_DVY: begin
        dvy_d = prod[27:16];
        state_d = S_TK_SCAN;
      end
      S_TK_SCAN: begin
        if (alive_q[idx_q]) begin
          state_d = S_TK_VY;
        end else if (is_last) begin
          state_d = S_TK_FLUSH;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_TK_VY: begin
        if (vy_sum > (VEL_W+2)'(4095)) begin
          vy_d = 13'sh0FFF;
        end else begin
          vy_d = vy_sum[VEL_W-1:0];
        end
        mul_en = 1'b1;
        mul_a = MUL_A_W'(rd_q.vx);
        mul_b = $signed({1'b0, SS_W'(ss_q)});
        state_d = S_TK_MX;
      end
      S_TK_MX: begin
        mul_en = 1'b1;
        mul_a = prod[MUL_A_W-1:0];
        mul_b = $signed({1'b0, dt});
        state_d = S_TK_MY;
      end
      S_TK_MY: begin
        px_d = pos_sat;
        mul_en = 1'b1;
        mul_a = MUL_A_W'(vy_q);
        mul_b = $signed({1'b0, SS_W'(ss_q)});
        state_d = S_TK_MY2;
      end
      S_TK_MY2: begin
        mul_en = 1'b1;
        mul_a = prod[MUL_A_W-1:0];
        mul_b = $signed({1'b0, dt});
        state_d = S_TK_WB;
      end
      S_TK_WB: begin
        if (!(life_new != '0 && pend_v_q && !out_free)) begin
          wdata.x = px_q;
          wdata.y = pos_sat;
          wdata.vy = vy_q;
          wdata.life = life_new;
          we = 1'b1;
          alive_d[idx_q] = (life_new != '0);
          if (life_new != '0) begin
            if (pend_v_q) begin
              out_d = pend_q;
              out_v_d = 1'b1;
            end
            pend_v_d = 1'b1;
            pend_d.kind = KIND_REPORT;
            pend_d.ok = 1'b0;
            pend_d.slot = SLOT_W'(idx_q);
            pend_d.px = px_q;
            pend_d.py = pos_sat;
            pend_d.green = rd_q.green;
            pend_d.alpha = alpha_of(life_new);
            pend_d.last = 1'b0;
          end
          if (is_last) begin
            state_d = S_TK_FLUSH;
          end else begin
            idx_d = idx_q + 1'b1;
            state_d = S_TK_SCAN;
          end
        end
      end
      S_TK_FLUSH: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_d = pend_q;
          out_d.last = 1'b1;
          out_v_d = 1'b1;
          pend_v_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      alive_q <= '0;
      pend_v_q <= 1'b0;
      out_v_q <= 1'b0;
      idx_q <= '0;
      grav_q <= GRAV_W'(768);
      ss_q <= SS_W'(60);
      slife_q <= LIFE_W'(65536);
    end else begin
      state_q <= state_d;
      alive_q <= alive_d;
      pend_v_q <= pend_v_d;
      out_v_q <= out_v_d;
      idx_q <= idx_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_GRAVITY: grav_q <= cfg_data_i[GRAV_W-1:0];
          REG_SPEED_SCALE: ss_q <= cfg_data_i[SS_W-1:0];
          REG_SPAWN_LIFE: slife_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    in_q <= in_d;
    dvy_q <= dvy_d;
    vy_q <= vy_d;
    px_q <= px_d;
    pend_q <= pend_d;
    out_q <= out_d;
  end

  // Particle memory: one write and one registered read, both at idx_q
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[idx_q] <= wdata;
    end
    rd_q <= mem[idx_q];
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser = out_q.kind;
  assign m_axis_tlast = out_q.last;
  assign m_axis_tdata = {5'b0, out_q.alpha, out_q.green, out_q.py, out_q.px,
                         out_q.slot, out_q.ok};

  // A held report never outlives its tick
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_v_q) else $error("report left pending in idle");

  // Writeback only ever touches a live slot
  a_wb_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TK_WB |-> alive_q[idx_q]) else $error("writeback on dead slot");

  // An accepted beat always leaves idle
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE) else $error("accepted beat not started");

  // Spawn acknowledgement always closes its beat
  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.kind == KIND_ACK |-> out_q.last) else $error("ack without last");

endmodule

// ===== design/ptu_mul.sv =====
module ptu_mul
  import ptu_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [MUL_P_W-1:0] p_o
);

  logic signed [MUL_P_W-1:0] p_q;

  // Registered signed product, held while not enabled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

// ===== tb/sv/particle_table_update_test.sv =====
`timescale 1ns / 1ps

module particle_table_update_test;
  import ptu_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 500;
  localparam int STALL_LIMIT = 20000;

  // Handshake pacing modes
  typedef enum int {PACE_NONE, PACE_SRC, PACE_SINK, PACE_BOTH} pace_e;

  typedef struct {
    logic              op;
    logic [10:0]       x;
    logic [10:0]       y;
    logic [VEL_W-1:0]  vx;
    logic [VEL_W-1:0]  vy;
    logic [COL_W-1:0]  green;
    logic [DT_W-1:0]   dt;
  } cmd_t;

  typedef struct {
    cmd_t  cmd;
    bit    typed;
    beat_t want;
  } row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [71:0]       s_axis_tdata;
  logic              s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [63:0]       m_axis_tdata;
  logic              m_axis_tuser;
  logic              m_axis_tlast;
  logic              cfg_we_i;
  logic [1:0]        cfg_idx_i;
  logic [CFG_W-1:0]  cfg_data_i;

  // Predictor copy of configuration and particle table
  logic [GRAV_W-1:0] grav_m;
  logic [SS_W-1:0]   scale_m;
  logic [LIFE_W-1:0] life_init_m;
  logic [LIFE_W-1:0] life_m [NUM_PARTICLES];
  longint            xpos_m [NUM_PARTICLES];
  longint            ypos_m [NUM_PARTICLES];
  longint            xvel_m [NUM_PARTICLES];
  longint            yvel_m [NUM_PARTICLES];
  logic [COL_W-1:0]  green_m [NUM_PARTICLES];

  beat_t  fresh_q[$];
  beat_t  pending_q[$];
  pace_e  pace;
  int     sink_hold;
  int     errors;
  int     n_cmds, n_beats, n_full, n_spawns, n_ticks;
  int     quiet;
  int     p_spawn;
  bit     wide_dt;

  particle_table_update dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [7:0] opacity(input logic [LIFE_W-1:0] life);
    longint a;
    a = (longint'(life) * 255) >> 16;
    return (a > 255) ? 8'd255 : a[7:0];
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Work out the results of one command and update the table copy
  task automatic advance_table(input cmd_t c);
    beat_t  b;
    longint dvy, vy, dx, dy;
    bit     found;
    fresh_q.delete();
    found = 1'b0;
    if (c.op == OP_SPAWN) begin
      for (int i = 0; i < NUM_PARTICLES && !found; i++) begin
        if (life_m[i] == '0) begin
          found = 1'b1;
          xpos_m[i] = longint'(c.x) << 6;
          ypos_m[i] = longint'(c.y) << 6;
          xvel_m[i] = longint'($signed(c.vx));
          yvel_m[i] = longint'($signed(c.vy));
          green_m[i] = c.green;
          life_m[i] = life_init_m;
          b = '{kind: KIND_ACK, ok: 1'b1, slot: i[SLOT_W-1:0], px: xpos_m[i][POS_W-1:0],
                py: ypos_m[i][POS_W-1:0], green: c.green, alpha: opacity(life_init_m),
                last: 1'b1};
          fresh_q.push_back(b);
        end
      end
      if (!found) begin
        b = '{kind: KIND_ACK, ok: 1'b0, slot: '0, px: '0, py: '0, green: '0, alpha: '0,
              last: 1'b1};
        fresh_q.push_back(b);
      end
    end else begin
      dvy = (longint'(grav_m) * longint'(c.dt)) >> 16;
      for (int i = 0; i < NUM_PARTICLES; i++) begin
        if (life_m[i] != '0) begin
          vy = clamp(yvel_m[i] + dvy, -4096, 4095);
          yvel_m[i] = vy;
          dx = (xvel_m[i] * longint'(scale_m) * longint'(c.dt)) >>> 18;
          dy = (vy * longint'(scale_m) * longint'(c.dt)) >>> 18;
          xpos_m[i] = clamp(xpos_m[i] + dx, -131072, 131071);
          ypos_m[i] = clamp(ypos_m[i] + dy, -131072, 131071);
          life_m[i] = (life_m[i] > c.dt) ? life_m[i] - c.dt : '0;
          if (life_m[i] != '0) begin
            b = '{kind: KIND_REPORT, ok: 1'b0, slot: i[SLOT_W-1:0],
                  px: xpos_m[i][POS_W-1:0], py: ypos_m[i][POS_W-1:0], green: green_m[i],
                  alpha: opacity(life_m[i]), last: 1'b0};
            fresh_q.push_back(b);
          end
        end
      end
      if (fresh_q.size() > 0) fresh_q[$].last = 1'b1;
    end
  endtask

  // Write one register while idle and mirror it
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_GRAVITY:     grav_m = val[GRAV_W-1:0];
      REG_SPEED_SCALE: scale_m = val[SS_W-1:0];
      REG_SPAWN_LIFE:  life_init_m = val[LIFE_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one command; predict on acceptance
  task automatic offer(input cmd_t c, input bit typed, input beat_t want);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.op;
    s_axis_tdata  <= {c.dt, c.green, c.vy, c.vx, c.y, c.x};
    do @(posedge clk_i); while (!s_axis_tready);
    advance_table(c);
    if (typed) fresh_q = '{want};
    foreach (fresh_q[k]) pending_q.push_back(fresh_q[k]);
    n_cmds++;
    if (c.op == OP_SPAWN) n_spawns++; else n_ticks++;
    if ((pace == PACE_SRC && $urandom_range(99) < 82) ||
        (pace == PACE_BOTH && $urandom_range(99) < 7)) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Pause the source until every result is back, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.op    = ($urandom_range(99) < p_spawn) ? OP_SPAWN : OP_TICK;
    c.x     = 11'($urandom_range(2047));
    c.y     = 11'($urandom_range(2047));
    c.vx    = VEL_W'($urandom());
    c.vy    = VEL_W'($urandom());
    c.green = COL_W'($urandom_range(255));
    if (wide_dt && $urandom_range(3) == 0) c.dt = DT_W'($urandom());
    else if ($urandom_range(9) == 0) c.dt = '0;
    else c.dt = DT_W'($urandom_range(1, 3000));
    return c;
  endfunction

  task automatic run_random(input int count);
    beat_t none;
    none = '0;
    repeat (count) offer(rand_cmd(), 1'b0, none);
    drain();
  endtask

  task automatic cmp_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d got %0d", $realtime, name, want, got);
    end
  endtask

  // Result sink: check each beat and randomize backpressure
  always @(posedge clk_i) begin
    beat_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_beats++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none got %h", $realtime,
                 m_axis_tdata);
      end else begin
        w = pending_q.pop_front();
        if (!w.ok && w.kind == KIND_ACK) n_full++;
        cmp_field("kind", w.kind, m_axis_tuser);
        cmp_field("spawned_ok", w.ok, m_axis_tdata[0]);
        cmp_field("slot", w.slot, m_axis_tdata[6:1]);
        cmp_field("pos_x", w.px, $signed(m_axis_tdata[24:7]));
        cmp_field("pos_y", w.py, $signed(m_axis_tdata[42:25]));
        cmp_field("green", w.green, m_axis_tdata[50:43]);
        cmp_field("alpha", w.alpha, m_axis_tdata[58:51]);
        cmp_field("last", w.last, m_axis_tlast);
      end
    end
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (pace == PACE_SINK) begin
      m_axis_tready <= ($urandom_range(99) >= 82);
    end else if (pace == PACE_BOTH) begin
      m_axis_tready <= ($urandom_range(99) >= 7);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, quiet);
      $display("[particle_table_update] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    row_t  rows[$];
    beat_t none;
    none = '0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_SPAWN;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_GRAVITY;
    cfg_data_i = '0;
    pace = PACE_NONE;
    sink_hold = 0;
    errors = 0;
    quiet = 0;
    n_cmds = 0; n_beats = 0; n_full = 0; n_spawns = 0; n_ticks = 0;
    p_spawn = 50;
    wide_dt = 1'b1;
    grav_m = 12'd768;
    scale_m = 8'd60;
    life_init_m = 17'd65536;
    foreach (life_m[i]) begin
      life_m[i] = '0;
      xpos_m[i] = 0; ypos_m[i] = 0; xvel_m[i] = 0; yvel_m[i] = 0; green_m[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: extremes, empty tick, zero step, dying particles, corner speeds
    rows.push_back('{'{OP_TICK, 0, 0, 0, 0, 0, 16'd100}, 1'b0, none});
    rows.push_back('{'{OP_SPAWN, 11'd2047, 11'd2047, 13'h1000, 13'h0FFF, 8'd255, 16'hFFFF},
                   1'b1, '{KIND_ACK, 1'b1, 6'd0, 18'sd131008, 18'sd131008, 8'd255, 8'd255,
                           1'b1}});
    rows.push_back('{'{OP_SPAWN, 0, 0, 0, 0, 0, 0}, 1'b1,
                   '{KIND_ACK, 1'b1, 6'd1, 18'sd0, 18'sd0, 8'd0, 8'd255, 1'b1}});
    rows.push_back('{'{OP_SPAWN, 11'd1024, 11'd5, 13'h0FFF, 13'h1000, 8'd128, 0}, 1'b0, none});
    rows.push_back('{'{OP_TICK, 0, 0, 0, 0, 0, 16'd0}, 1'b0, none});
    rows.push_back('{'{OP_TICK, 0, 0, 0, 0, 0, 16'd1}, 1'b0, none});
    rows.push_back('{'{OP_TICK, 0, 0, 0, 0, 0, 16'd40000}, 1'b0, none});
    rows.push_back('{'{OP_TICK, 0, 0, 0, 0, 0, 16'hFFFF}, 1'b0, none});
    rows.push_back('{'{OP_SPAWN, 11'd1, 11'd2046, 13'h1555, 13'h0AAA, 8'd85, 16'h5555},
                   1'b0, none});
    rows.push_back('{'{OP_SPAWN, 11'd2046, 11'd1, 13'h0AAA, 13'h1555, 8'd170, 16'hAAAA},
                   1'b0, none});
    rows.push_back('{'{OP_TICK, 0, 0, 0, 0, 0, 16'h8000}, 1'b0, none});
    rows.push_back('{'{OP_TICK, 0, 0, 0, 0, 0, 16'h7FFF}, 1'b0, none});
    foreach (rows[r]) offer(rows[r].cmd, rows[r].typed, rows[r].want);
    drain();

    // Strong gravity, top speed, longest life: fill the table until full
    write_reg(REG_GRAVITY, 17'd4095);
    write_reg(REG_SPEED_SCALE, 17'd255);
    write_reg(REG_SPAWN_LIFE, 17'd131071);
    pace = PACE_SRC;
    p_spawn = 80;
    wide_dt = 1'b0;
    run_random(100);

    // No gravity, no motion, shortest life; receiver stalls
    write_reg(REG_GRAVITY, 17'd0);
    write_reg(REG_SPEED_SCALE, 17'd0);
    write_reg(REG_SPAWN_LIFE, 17'd1);
    pace = PACE_SINK;
    p_spawn = 50;
    wide_dt = 1'b1;
    run_random(70);

    // Zero spawn life and an ignored register index; long receiver hold-off
    write_reg(REG_UNUSED, 17'h1FFFF);
    write_reg(REG_SPAWN_LIFE, 17'd0);
    write_reg(REG_GRAVITY, 17'd100);
    write_reg(REG_SPEED_SCALE, 17'd60);
    pace = PACE_BOTH;
    sink_hold = 3000;
    run_random(60);

    // Mid-range settings, spawn-heavy traffic
    write_reg(REG_SPAWN_LIFE, 17'd40000);
    write_reg(REG_GRAVITY, 17'd768);
    pace = PACE_NONE;
    p_spawn = 65;
    wide_dt = 1'b0;
    run_random(120);

    write_reg(REG_SPAWN_LIFE, 17'd65536);
    write_reg(REG_SPEED_SCALE, 17'd200);
    pace = PACE_BOTH;
    p_spawn = 55;
    wide_dt = 1'b1;
    run_random(120);

    $display("covered %0d commands (%0d spawns, %0d ticks), %0d result beats checked",
             n_cmds, n_spawns, n_ticks, n_beats);
    $display("%0d spawns hit a full table, settings swept across register extremes",
             n_full);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("[particle_table_update] OK");
    end else begin
      $display("[particle_table_update] ERROR");
    end
    $finish;
  end

endmodule
